@@ rtl/core/cbo_pkg.sv @@
package cbo_pkg;

	// coordinate width, signed Q(n-9).8
	localparam int COORD_BITS = 24;

	// one query beat
	typedef struct packed {
		logic signed [COORD_BITS-1:0] circle_x;
		logic signed [COORD_BITS-1:0] circle_y;
		logic        [COORD_BITS-2:0] radius;
		logic signed [COORD_BITS-1:0] box_left;
		logic signed [COORD_BITS-1:0] box_right;
		logic signed [COORD_BITS-1:0] box_top;
		logic signed [COORD_BITS-1:0] box_bottom;
	} cbo_req_t;

	// one result beat
	typedef struct packed {
		logic                         hit;
		logic signed [COORD_BITS-1:0] push_x;
		logic signed [COORD_BITS-1:0] push_y;
	} cbo_res_t;

endpackage

@@ rtl/core/cbo_sqrt_cell.sv @@
module cbo_sqrt_cell #(
	parameter int LW  = 25,
	parameter int BIT = 0,
	parameter int SBW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  logic [2*LW-2:0] resid,
	input  logic [LW-1:0]   root,
	input  logic [SBW-1:0]  side,
	output logic            cell_valid,
	output logic [2*LW-2:0] cell_resid,
	output logic [LW-1:0]   cell_root,
	output logic [SBW-1:0]  cell_side
);

	localparam int TW = 2*LW;

	logic [TW-1:0] trial;
	logic          take;

	// (root + 2^bit)^2 - root^2, root holds only bits above this one
	assign trial = (TW'(root) << (BIT+1)) | (TW'(1) << (2*BIT));
	assign take  = {1'b0, resid} >= trial;

	// valid travels with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid <= 1'b0;
		end else begin
			cell_valid <= valid;
		end
	end

	// one root bit per cell
	always_ff @(posedge clk) begin
		cell_resid <= take ? (resid - trial[TW-2:0]) : resid;
		cell_root  <= take ? (root | (LW'(1) << BIT)) : root;
		cell_side  <= side;
	end

endmodule

@@ rtl/core/cbo_div_cell.sv @@
module cbo_div_cell #(
	parameter int NW  = 47,
	parameter int LW  = 25,
	parameter int QW  = 23,
	parameter int BIT = 0,
	parameter int SBW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  logic [LW-1:0]       den,
	input  logic [1:0][NW-1:0]  rem,
	input  logic [1:0][QW-1:0]  quo,
	input  logic [SBW-1:0]      side,
	output logic                cell_valid,
	output logic [LW-1:0]       cell_den,
	output logic [1:0][NW-1:0]  cell_rem,
	output logic [1:0][QW-1:0]  cell_quo,
	output logic [SBW-1:0]      cell_side
);

	localparam int TW = NW + LW;

	logic [TW-1:0]      shifted;
	logic [1:0][NW-1:0] rem_nxt;
	logic [1:0][QW-1:0] quo_nxt;

	assign shifted = TW'(den) << BIT;

	// restoring step on both lanes against the shared divisor
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (TW'(rem[k]) >= shifted) begin
				rem_nxt[k] = rem[k] - shifted[NW-1:0];
				quo_nxt[k] = quo[k] | (QW'(1) << BIT);
			end else begin
				rem_nxt[k] = rem[k];
				quo_nxt[k] = quo[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid <= 1'b0;
		end else begin
			cell_valid <= valid;
		end
	end

	always_ff @(posedge clk) begin
		cell_den  <= den;
		cell_rem  <= rem_nxt;
		cell_quo  <= quo_nxt;
		cell_side <= side;
	end

endmodule

@@ rtl/core/circle_box_overlap.sv @@
// circle against axis-aligned box overlap test with push-out vector.
// query channel: a beat (req) is taken at a rising edge with start high and
// busy low; busy is held low, so a new query may be issued every cycle.
// result channel: done is high for exactly one cycle with res valid; the
// receiver cannot stall, it must take the beat in that cycle.
// between the accepting edge and the done beat a query passes three front
// stages (clamp, products, sum and compare), one square-root cell per root
// bit, one divider cell per quotient bit and one output stage.
// throughput is one query per cycle; every cell holds one query in flight.
// hit compares the squared distance to the squared radius; push is
// radius*d/|d| - d per axis, rounded half away from zero and saturated,
// and zero when the centre lies inside or on the box.
// reset clears all valid flags in the pipe; queries in flight are dropped
// and no done strobe follows until new queries arrive.
module circle_box_overlap (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cbo_pkg::cbo_req_t req,
	output logic             done,
	output cbo_pkg::cbo_res_t res
);

	import cbo_pkg::*;

	localparam int CW     = COORD_BITS;
	localparam int DW     = CW + 1;
	localparam int MW     = CW;
	localparam int RW     = CW - 1;
	localparam int LW     = CW + 1;
	localparam int SW     = 2*LW - 1;
	localparam int NW     = RW + MW;
	localparam int QW     = CW - 1;
	localparam int PW     = CW + 2;
	localparam int SQ_SBW = 2 + 2*DW + 2*NW;
	localparam int DV_SBW = 2 + 2*DW;

	// per-axis push with rounding, sign and saturation
	function automatic logic signed [CW-1:0] push_axis(
		input logic [QW-1:0]        q,
		input logic [NW-1:0]        rem,
		input logic [LW-1:0]        den,
		input logic signed [DW-1:0] d
	);
		logic [LW:0]          rem2;
		logic                 up;
		logic signed [PW-1:0] qs;
		logic signed [PW-1:0] p;
		logic signed [CW-1:0] r;
		rem2 = {rem[LW-1:0], 1'b0};
		up   = rem2 >= {1'b0, den};
		qs   = PW'(q) + PW'(up);
		if (d < 0) begin
			qs = -qs;
		end
		p = qs - PW'(d);
		if (p[PW-1:CW-1] != '0 && p[PW-1:CW-1] != '1) begin
			r = p[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			r = p[CW-1:0];
		end
		return r;
	endfunction

	logic                 accept;
	logic signed [DW-1:0] dx_c, dy_c;
	logic                 valid_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [RW-1:0]        r_s1;
	logic [MW-1:0]        ax, ay;
	logic                 valid_s2, zero_s2;
	logic [2*MW-1:0]      sqx_s2, sqy_s2;
	logic [2*RW-1:0]      rr_s2;
	logic [NW-1:0]        nx_s2, ny_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic [SW-1:0]        s_sum;
	logic                 valid_s3;
	logic [SW-1:0]        s_s3;
	logic [SQ_SBW-1:0]    side_s3;

	logic                 sq_valid [0:LW];
	logic [SW-1:0]        sq_res   [0:LW];
	logic [LW-1:0]        sq_root  [0:LW];
	logic [SQ_SBW-1:0]    sq_side  [0:LW];

	logic                 dv_valid [0:QW];
	logic [LW-1:0]        dv_den   [0:QW];
	logic [1:0][NW-1:0]   dv_rem   [0:QW];
	logic [1:0][QW-1:0]   dv_quo   [0:QW];
	logic [DV_SBW-1:0]    dv_side  [0:QW];

	logic                 fin_hit, fin_zero;
	logic signed [DW-1:0] fin_dx, fin_dy;
	logic                 done_q;
	cbo_res_t             res_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// distance from the clamped point to the centre, per axis
	always_comb begin
		if (req.circle_x < req.box_left) begin
			dx_c = DW'(req.circle_x) - DW'(req.box_left);
		end else if (req.circle_x > req.box_right) begin
			dx_c = DW'(req.circle_x) - DW'(req.box_right);
		end else begin
			dx_c = '0;
		end
		if (req.circle_y < req.box_top) begin
			dy_c = DW'(req.circle_y) - DW'(req.box_top);
		end else if (req.circle_y > req.box_bottom) begin
			dy_c = DW'(req.circle_y) - DW'(req.box_bottom);
		end else begin
			dy_c = '0;
		end
	end

	assign ax = dx_s1[DW-1] ? MW'(-dx_s1) : MW'(dx_s1);
	assign ay = dy_s1[DW-1] ? MW'(-dy_s1) : MW'(dy_s1);

	assign s_sum = SW'(sqx_s2) + SW'(sqy_s2);

	// front stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// clamp, products, squared distance and hit
	always_ff @(posedge clk) begin
		dx_s1   <= dx_c;
		dy_s1   <= dy_c;
		r_s1    <= req.radius;
		sqx_s2  <= ax * ax;
		sqy_s2  <= ay * ay;
		rr_s2   <= r_s1 * r_s1;
		nx_s2   <= NW'(r_s1) * NW'(ax);
		ny_s2   <= NW'(r_s1) * NW'(ay);
		zero_s2 <= (ax == '0) && (ay == '0);
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		s_s3    <= s_sum;
		side_s3 <= {s_sum <= SW'(rr_s2), zero_s2, dx_s2, dy_s2, nx_s2, ny_s2};
	end

	// square-root chain, most significant root bit first
	assign sq_valid[0] = valid_s3;
	assign sq_res[0]   = s_s3;
	assign sq_root[0]  = '0;
	assign sq_side[0]  = side_s3;

	for (genvar k = 0; k < LW; k++) begin : g_sq
		cbo_sqrt_cell #(
			.LW  (LW),
			.BIT (LW-1-k),
			.SBW (SQ_SBW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid      (sq_valid[k]),
			.resid      (sq_res[k]),
			.root       (sq_root[k]),
			.side       (sq_side[k]),
			.cell_valid (sq_valid[k+1]),
			.cell_resid (sq_res[k+1]),
			.cell_root  (sq_root[k+1]),
			.cell_side  (sq_side[k+1])
		);
	end

	// divider chain, both axes against the distance length
	assign dv_valid[0]  = sq_valid[LW];
	assign dv_den[0]    = sq_root[LW];
	assign dv_rem[0][1] = sq_side[LW][2*NW-1:NW];
	assign dv_rem[0][0] = sq_side[LW][NW-1:0];
	assign dv_quo[0]    = '0;
	assign dv_side[0]   = sq_side[LW][SQ_SBW-1:2*NW];

	for (genvar k = 0; k < QW; k++) begin : g_dv
		cbo_div_cell #(
			.NW  (NW),
			.LW  (LW),
			.QW  (QW),
			.BIT (QW-1-k),
			.SBW (DV_SBW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid      (dv_valid[k]),
			.den        (dv_den[k]),
			.rem        (dv_rem[k]),
			.quo        (dv_quo[k]),
			.side       (dv_side[k]),
			.cell_valid (dv_valid[k+1]),
			.cell_den   (dv_den[k+1]),
			.cell_rem   (dv_rem[k+1]),
			.cell_quo   (dv_quo[k+1]),
			.cell_side  (dv_side[k+1])
		);
	end

	assign fin_hit  = dv_side[QW][2*DW+1];
	assign fin_zero = dv_side[QW][2*DW];
	assign fin_dx   = dv_side[QW][2*DW-1:DW];
	assign fin_dy   = dv_side[QW][DW-1:0];

	// output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid[QW];
		end
	end

	always_ff @(posedge clk) begin
		res_q.hit <= fin_hit;
		if (fin_zero) begin
			res_q.push_x <= '0;
			res_q.push_y <= '0;
		end else begin
			res_q.push_x <= push_axis(dv_quo[QW][1], dv_rem[QW][1], dv_den[QW], fin_dx);
			res_q.push_y <= push_axis(dv_quo[QW][0], dv_rem[QW][0], dv_den[QW], fin_dy);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ tb/tb_circle_box_overlap.sv @@
module tb_circle_box_overlap;
	timeunit 1ns;
	timeprecision 1ps;

	import cbo_pkg::*;

	localparam longint PUSH_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint PUSH_MIN = -PUSH_MAX - 1;
	localparam int     DRAIN_CYCLES = 80;

	typedef struct {
		cbo_req_t q;
		int       gap_pct;
	} query_slot_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	cbo_req_t req;
	logic     done;
	cbo_res_t res;

	query_slot_t pending_queries[$];
	cbo_res_t    expected_results[$];
	int          fail_count;
	logic        beat_taken;

	circle_box_overlap dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// nearest box point on one axis, minimum edge tested first
	function automatic longint clamp_to_edge(longint c, longint lo, longint hi);
		if (c < lo)
			return lo;
		if (c > hi)
			return hi;
		return c;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] s);
		logic [63:0]  root;
		logic [63:0]  cand;
		logic [127:0] sq;
		root = 0;
		for (int i = 33; i >= 0; i--) begin
			cand = root | (64'd1 << i);
			sq = 128'(cand) * 128'(cand);
			if (sq <= s)
				root = cand;
		end
		return root;
	endfunction

	// radius*|d|/len rounded half away from zero, signed, minus d, saturated
	function automatic logic [COORD_BITS-1:0] push_axis(logic [63:0] r, longint d,
			logic [63:0] len);
		logic [63:0] mag_d;
		logic [63:0] num;
		logic [63:0] quo;
		logic [63:0] rem;
		longint      p;
		mag_d = (d < 0) ? 64'(-d) : 64'(d);
		num = r * mag_d;
		quo = num / len;
		rem = num % len;
		if (rem * 2 >= len)
			quo = quo + 1;
		p = (d < 0) ? -longint'(quo) : longint'(quo);
		p = p - d;
		if (p > PUSH_MAX)
			p = PUSH_MAX;
		if (p < PUSH_MIN)
			p = PUSH_MIN;
		return p[COORD_BITS-1:0];
	endfunction

	function automatic cbo_res_t predict_overlap(cbo_req_t q);
		cbo_res_t     o;
		longint       cx;
		longint       cy;
		longint       dx;
		longint       dy;
		logic [63:0]  r;
		logic [127:0] dist_sq;
		logic [127:0] rad_sq;
		logic [63:0]  len;
		cx = q.circle_x;
		cy = q.circle_y;
		r = 64'(q.radius);
		dx = cx - clamp_to_edge(cx, longint'(q.box_left), longint'(q.box_right));
		dy = cy - clamp_to_edge(cy, longint'(q.box_top), longint'(q.box_bottom));
		dist_sq = 128'(dx * dx) + 128'(dy * dy);
		rad_sq = 128'(r) * 128'(r);
		o.hit = (dist_sq <= rad_sq);
		o.push_x = '0;
		o.push_y = '0;
		if (dx != 0 || dy != 0) begin
			len = floor_sqrt(dist_sq);
			o.push_x = push_axis(r, dx, len);
			o.push_y = push_axis(r, dy, len);
		end
		return o;
	endfunction

	function automatic logic [COORD_BITS-1:0] any_coord();
		return COORD_BITS'($urandom);
	endfunction

	// coordinate within +-span of a base point, wrapped to the field
	function automatic logic [COORD_BITS-1:0] near_coord(longint base, int span);
		return COORD_BITS'(base + $signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic add_query(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
			logic [COORD_BITS-2:0] r, logic [COORD_BITS-1:0] l,
			logic [COORD_BITS-1:0] rt, logic [COORD_BITS-1:0] t,
			logic [COORD_BITS-1:0] b, int gap_pct);
		query_slot_t s;
		s.q.circle_x = cx;
		s.q.circle_y = cy;
		s.q.radius = r;
		s.q.box_left = l;
		s.q.box_right = rt;
		s.q.box_top = t;
		s.q.box_bottom = b;
		s.gap_pct = gap_pct;
		pending_queries.insert(pending_queries.size(), s);
	endtask

	// a well-formed box with a circle placed around it, or else a query with all fields random
	task automatic add_random_query(int gap_pct);
		longint l;
		longint t;
		longint w;
		longint h;
		int     span;
		int     pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			add_query(any_coord(), any_coord(), (COORD_BITS - 1)'($urandom), any_coord(),
				any_coord(), any_coord(), any_coord(), gap_pct);
		end else begin
			span = (pick < 5) ? 2000 : (pick < 8) ? 200000 : 4000000;
			l = longint'($signed(near_coord(0, span)));
			t = longint'($signed(near_coord(0, span)));
			w = $urandom_range(span);
			h = $urandom_range(span);
			add_query(near_coord(l + w / 2, span), near_coord(t + h / 2, span),
				(COORD_BITS - 1)'($urandom_range(span)), COORD_BITS'(l),
				COORD_BITS'(l + w), COORD_BITS'(t), COORD_BITS'(t + h), gap_pct);
		end
	endtask

	// stimulus and end of run
	initial begin
		logic [COORD_BITS-1:0] cmax;
		logic [COORD_BITS-1:0] cmin;
		logic [COORD_BITS-2:0] rmax;
		cmax = {1'b0, {(COORD_BITS - 1){1'b1}}};
		cmin = {1'b1, {(COORD_BITS - 1){1'b0}}};
		rmax = '1;
		fail_count = 0;
		arst_n = 1'b0;
		// centre inside, on an edge, on a corner
		add_query(24'd100, 24'd100, 23'd50, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		add_query(24'd0, 24'd100, 23'd50, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		add_query(24'd256, 24'd256, 23'd0, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		// outside on each side, grazing and missing
		add_query(24'd356, 24'd100, 23'd100, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		add_query(-24'sd100, 24'd100, 23'd99, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		add_query(24'd100, -24'sd300, 23'd500, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		add_query(24'd100, 24'd900, 23'd1, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		add_query(24'd556, 24'd556, 23'd424, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		add_query(24'd556, 24'd556, 23'd425, 24'd0, 24'd256, 24'd0, 24'd256, 0);
		// radius zero and largest radius
		add_query(24'd1000, 24'd5, 23'd0, 24'd0, 24'd10, 24'd0, 24'd10, 0);
		add_query(24'd1000, 24'd5, rmax, 24'd0, 24'd10, 24'd0, 24'd10, 0);
		// field extremes, saturating push
		add_query(cmax, cmax, rmax, cmin, cmin, cmin, cmin, 0);
		add_query(cmin, cmin, rmax, cmax, cmax, cmax, cmax, 0);
		add_query(cmax, 24'd0, rmax, cmin, cmin, 24'd0, 24'd0, 0);
		add_query(cmin, cmax, 23'd0, cmax, cmax, cmin, cmin, 0);
		add_query(cmin, cmin, rmax, cmin, cmax, cmin, cmax, 0);
		// inverted boxes
		add_query(24'd100, 24'd100, 23'd300, 24'd256, 24'd0, 24'd0, 24'd256, 0);
		add_query(24'd100, 24'd100, 23'd300, 24'd0, 24'd256, 24'd256, 24'd0, 0);
		add_query(-24'sd50, 24'd900, 23'd2000, 24'd256, 24'd0, 24'd256, 24'd0, 0);
		// rounding of a fractional quotient against a point box
		add_query(24'd3, 24'd4, 23'd1, 24'd0, 24'd0, 24'd0, 24'd0, 0);
		add_query(-24'sd3, -24'sd4, 23'd7, 24'd0, 24'd0, 24'd0, 24'd0, 0);
		for (int i = 0; i < 300; i++)
			add_random_query(8);
		for (int i = 0; i < 300; i++)
			add_random_query(68);
		for (int i = 0; i < 300; i++)
			add_random_query(0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_queries.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	// driver: query beats change on the falling edge
	initial begin
		start = 1'b0;
		req = '0;
	end

	always @(negedge clk) begin
		if (arst_n && !(start && !beat_taken)) begin
			if (pending_queries.size() > 0 &&
					$urandom_range(99) >= pending_queries[0].gap_pct) begin
				start <= 1'b1;
				req <= pending_queries.pop_front().q;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: accepted queries and result beats at the rising edge
	always @(posedge clk) begin
		cbo_res_t want;
		beat_taken = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				beat_taken = 1'b1;
				expected_results.insert(expected_results.size(), predict_overlap(req));
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no query outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (res.hit !== want.hit) begin
						$error("hit expected %0d got %0d", want.hit, res.hit);
						fail_count++;
					end
					if (res.push_x !== want.push_x) begin
						$error("push_x expected %0d got %0d", want.push_x, res.push_x);
						fail_count++;
					end
					if (res.push_y !== want.push_y) begin
						$error("push_y expected %0d got %0d", want.push_y, res.push_y);
						fail_count++;
					end
				end
			end
		end
	end

endmodule
